### rtl/ams_pkg.sv
`timescale 1ns / 1ps

package ams_pkg;

    localparam int MELODY_STEPS = 8;
    localparam int KEY_COUNT    = 16;
    localparam int MELODY_LEN   = (MELODY_STEPS > 8) ? 8 : ((MELODY_STEPS < 1) ? 1 : MELODY_STEPS);

    localparam int KEY_NOTE_MS  = 25;
    localparam int BEEP_HZ      = 150;
    localparam int BEEP_MS      = 100;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_MESSAGE = 3'd1,
        OP_KEY     = 3'd2,
        OP_SILENCE = 3'd3,
        OP_BEEP    = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_TONE    = 2'd1,
        ACT_TIMED   = 2'd2,
        ACT_SILENCE = 2'd3
    } t_action;

    typedef struct packed {
        logic sound_enable;
        logic keypad_sound_enable;
        logic game_running;
    } t_cfg;

    typedef struct packed {
        logic        running;
        logic        alert_flag;
        logic [2:0]  step_index;
        logic [20:0] step_time_us;
    } t_seq_state;

    typedef struct packed {
        t_action    action;
        logic [9:0] tone_hz;
        logic [6:0] tone_ms;
        logic       melody_running;
        logic       alert_on;
    } t_result;

    function automatic logic [9:0] melody_hz(input logic [2:0] idx);
        logic [9:0] hz;
        case (idx)
            3'd0:    hz = 10'd988;
            3'd1:    hz = 10'd0;
            3'd2:    hz = 10'd494;
            3'd3:    hz = 10'd523;
            3'd4:    hz = 10'd0;
            3'd5:    hz = 10'd392;
            3'd6:    hz = 10'd0;
            default: hz = 10'd523;
        endcase
        return hz;
    endfunction

    function automatic logic [18:0] melody_us(input logic [2:0] idx);
        logic [18:0] us;
        case (idx)
            3'd0, 3'd2, 3'd3, 3'd5, 3'd6: us = 19'd100000;
            3'd1, 3'd4:                   us = 19'd50000;
            default:                      us = 19'd500000;
        endcase
        return us;
    endfunction

    function automatic logic [9:0] key_hz(input logic [3:0] key);
        logic [9:0] hz;
        case (key)
            4'd0:    hz = 10'd262;
            4'd1:    hz = 10'd294;
            4'd2:    hz = 10'd330;
            4'd3:    hz = 10'd349;
            4'd4:    hz = 10'd392;
            4'd5:    hz = 10'd440;
            4'd6:    hz = 10'd494;
            4'd7:    hz = 10'd523;
            4'd8:    hz = 10'd587;
            4'd9:    hz = 10'd659;
            4'd10:   hz = 10'd698;
            4'd11:   hz = 10'd784;
            4'd12:   hz = 10'd494;
            4'd13:   hz = 10'd494;
            4'd14:   hz = 10'd523;
            default: hz = 10'd440;
        endcase
        return hz;
    endfunction

endpackage

### rtl/alert_melody_sequencer.sv
`timescale 1ns / 1ps

// Alert melody sequencer: turns a stream of buzzer events into speaker commands.
// Input channel: i_in_valid / o_in_stall with opcode, key index and elapsed time.
// A transaction completes when i_in_valid is high and o_in_stall is low.
// Output channel: o_out_valid / i_out_stall; every event gives exactly one command
// (action, tone frequency, tone length, and the running and alert flags after it).
// Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data); the user
// must write it only while no event is in flight, which the block does not enforce.
// An event is first held in the input register; the state update and command decode
// then write the result register.
// Throughput is one event per cycle unless the receiver stalls; the state registers
// are written in the same cycle as the command, so the next event sees them at once.
// When the receiver stalls, the result register holds; an empty input register still
// takes one event, after which o_in_stall is high until the result is taken.
// Synchronous reset clears the melody state, both valid flags and restores the
// settings to sound on, keypad sounds on and no game running.

module alert_melody_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_opcode,
    input  logic [3:0]  i_key_index,
    input  logic [19:0] i_elapsed_us,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_action,
    output logic [9:0]  o_tone_hz,
    output logic [6:0]  o_tone_ms,
    output logic        o_melody_running,
    output logic        o_alert_on,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic        i_cfg_data
);
    import ams_pkg::*;

    t_cfg        cfg;
    t_seq_state  r_state;
    t_seq_state  n_state;
    t_result     n_result;
    t_result     r_result;

    logic        r_in_valid;
    logic [2:0]  r_opcode;
    logic [3:0]  r_key_index;
    logic [19:0] r_elapsed_us;
    logic        r_out_valid;

    logic out_free;
    logic advance;
    logic in_take;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    ams_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ams_step u_step (
        .i_cfg        (cfg),
        .i_state      (r_state),
        .i_opcode     (r_opcode),
        .i_key_index  (r_key_index),
        .i_elapsed_us (r_elapsed_us),
        .o_state      (n_state),
        .o_result     (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_opcode     <= i_opcode;
            r_key_index  <= i_key_index;
            r_elapsed_us <= i_elapsed_us;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_state <= n_state;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_action         = r_result.action;
    assign o_tone_hz        = r_result.tone_hz;
    assign o_tone_ms        = r_result.tone_ms;
    assign o_melody_running = r_result.melody_running;
    assign o_alert_on       = r_result.alert_on;

endmodule

### rtl/ams_cfg.sv
`timescale 1ns / 1ps

module ams_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic          i_cfg_data,
    output ams_pkg::t_cfg o_cfg
);
    import ams_pkg::*;

    localparam logic [1:0] REG_SOUND  = 2'd0;
    localparam logic [1:0] REG_KEYPAD = 2'd1;
    localparam logic [1:0] REG_GAME   = 2'd2;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sound_enable        <= 1'b1;
            r_cfg.keypad_sound_enable <= 1'b1;
            r_cfg.game_running        <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SOUND:  r_cfg.sound_enable        <= i_cfg_data;
                REG_KEYPAD: r_cfg.keypad_sound_enable <= i_cfg_data;
                REG_GAME:   r_cfg.game_running        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/ams_step.sv
`timescale 1ns / 1ps

module ams_step (
    input  ams_pkg::t_cfg       i_cfg,
    input  ams_pkg::t_seq_state i_state,
    input  logic [2:0]          i_opcode,
    input  logic [3:0]          i_key_index,
    input  logic [19:0]         i_elapsed_us,
    output ams_pkg::t_seq_state o_state,
    output ams_pkg::t_result    o_result
);
    import ams_pkg::*;

    t_seq_state n_state;
    t_action    n_action;
    logic [9:0] n_hz;
    logic [6:0] n_ms;
    logic [20:0] sum_us;
    logic [3:0]  next_step;
    logic [2:0]  wrap_step;
    logic        keep_running;

    always_comb begin
        n_state      = i_state;
        n_action     = ACT_NONE;
        n_hz         = '0;
        n_ms         = '0;
        sum_us       = i_state.step_time_us + 21'(i_elapsed_us);
        next_step    = {1'b0, i_state.step_index} + 4'd1;
        wrap_step    = (32'(next_step) >= MELODY_LEN) ? 3'd0 : next_step[2:0];
        keep_running = i_state.alert_flag || (32'(next_step) < MELODY_LEN);

        case (t_opcode'(i_opcode))
            OP_TICK: begin
                if (i_state.running) begin
                    if (!i_cfg.sound_enable) begin
                        // Step position and time are left where they were.
                        n_state.running    = 1'b0;
                        n_state.alert_flag = 1'b0;
                        n_action           = ACT_SILENCE;
                    end else if ({2'b00, sum_us} >= {4'd0, melody_us(i_state.step_index)}) begin
                        n_state.step_index   = wrap_step;
                        n_state.step_time_us = '0;
                        n_state.running      = keep_running;
                        if (!keep_running || melody_hz(wrap_step) == 10'd0) begin
                            n_action = ACT_SILENCE;
                        end else begin
                            n_action = ACT_TONE;
                            n_hz     = melody_hz(wrap_step);
                        end
                    end else begin
                        n_state.step_time_us = sum_us;
                    end
                end
            end
            OP_MESSAGE: begin
                if (i_cfg.sound_enable) begin
                    n_state.running      = 1'b1;
                    n_state.alert_flag   = 1'b1;
                    n_state.step_index   = '0;
                    n_state.step_time_us = '0;
                    if (melody_hz(3'd0) == 10'd0) begin
                        n_action = ACT_SILENCE;
                    end else begin
                        n_action = ACT_TONE;
                        n_hz     = melody_hz(3'd0);
                    end
                end
            end
            OP_KEY: begin
                if (!i_cfg.game_running && i_cfg.sound_enable) begin
                    if (i_cfg.keypad_sound_enable && 32'(i_key_index) < KEY_COUNT) begin
                        n_action = ACT_TIMED;
                        n_hz     = key_hz(i_key_index);
                        n_ms     = 7'(KEY_NOTE_MS);
                    end else begin
                        n_action = ACT_SILENCE;
                    end
                    n_state = '0;
                end
            end
            OP_SILENCE: begin
                n_action = ACT_SILENCE;
                n_state  = '0;
            end
            OP_BEEP: begin
                if (i_cfg.sound_enable && i_cfg.keypad_sound_enable) begin
                    n_action = ACT_TIMED;
                    n_hz     = 10'(BEEP_HZ);
                    n_ms     = 7'(BEEP_MS);
                end
            end
            default: ;
        endcase
    end

    assign o_state                 = n_state;
    assign o_result.action         = n_action;
    assign o_result.tone_hz        = n_hz;
    assign o_result.tone_ms        = n_ms;
    assign o_result.melody_running = n_state.running;
    assign o_result.alert_on       = n_state.alert_flag;

endmodule

### rtl/ams_checker.sv
`timescale 1ns / 1ps

module ams_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_action,
    input logic [9:0]  o_tone_hz,
    input logic [6:0]  o_tone_ms,
    input logic        o_melody_running,
    input logic        o_alert_on
);
    import ams_pkg::*;

    // The alert can only be on while the melody is being stepped.
    a_alert_implies_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_alert_on || o_melody_running))
        else $error("alert reported without a running melody");

    // A timed tone always carries a frequency and a length.
    a_timed_has_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_action == ACT_TIMED) |-> (o_tone_hz != 10'd0 && o_tone_ms != 7'd0))
        else $error("timed tone without frequency or length");

    // Continuous tones have a frequency and no length; other commands carry neither.
    a_fields_match_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_action != ACT_TIMED) |->
            (o_tone_ms == 7'd0 && ((o_action == ACT_TONE) == (o_tone_hz != 10'd0))))
        else $error("tone fields do not match the action");

    a_stalled_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_action) && $stable(o_tone_hz) && $stable(o_alert_on)))
        else $error("stalled transaction changed");

endmodule

bind alert_melody_sequencer ams_checker u_ams_checker (.*);
